// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/rts_pkg.sv -----
// ----------------------------------------------------------------------------
// Ready task selector package
// Types, codes and widths shared by the task selector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rts_pkg;

  localparam int TASK_COUNT_DEF = 8;
  localparam int VAL_W          = 16;
  localparam int ID_W           = 3;
  localparam int CHOSEN_W       = 4;
  localparam int POLICY_W       = 2;

  typedef enum logic [POLICY_W-1:0] {
    POL_RM   = 2'd0,
    POL_EDF  = 2'd1,
    POL_FIFO = 2'd2,
    POL_RR   = 2'd3
  } policy_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SCHED = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SCAN,
    SC_DRAIN,
    SC_HOLD
  } scan_state_t;

  typedef struct packed {
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] deadline;
    logic [VAL_W-1:0] release_time;
    logic [VAL_W-1:0] work;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scan_stat_t;

endpackage

`default_nettype wire

// ----- hdl/rts_ifs.sv -----
// ----------------------------------------------------------------------------
// Ready task selector channel interfaces
// Valid/ready channels for commands, results and the policy register.
// ----------------------------------------------------------------------------
`default_nettype none

interface rts_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  task_id;
  logic [15:0] period;
  logic [15:0] deadline;
  logic [15:0] release_time;
  logic [15:0] remaining_work;
  logic [15:0] now;

  modport source (
    output valid, cmd, task_id, period, deadline, release_time, remaining_work, now,
    input  ready
  );
  modport sink (
    input  valid, cmd, task_id, period, deadline, release_time, remaining_work, now,
    output ready
  );
endinterface

interface rts_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] chosen_task;
  logic       idle;

  modport source (output valid, chosen_task, idle, input ready);
  modport sink   (input valid, chosen_task, idle, output ready);
endinterface

interface rts_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] policy;

  modport source (output valid, policy, input ready);
  modport sink   (input valid, policy, output ready);
endinterface

`default_nettype wire

// ----- hdl/rts_table.sv -----
// ----------------------------------------------------------------------------
// Ready task selector entry table
// One-write, one-read task memory with registered read and per-entry valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_table #(
  parameter int TASK_COUNT = rts_pkg::TASK_COUNT_DEF,
  localparam int AW        = $clog2(TASK_COUNT)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire rts_pkg::entry_t wr_entry,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output rts_pkg::entry_t      rd_entry
);
  import rts_pkg::*;

  entry_t                  mem_r [TASK_COUNT];
  logic [TASK_COUNT-1:0]   vld_r;
  entry_t                  rd_data_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // An entry never written since reset reads as all zero, so it is never ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ----- hdl/rts_scan.sv -----
// ----------------------------------------------------------------------------
// Ready task selector scan sequencer
// Walks the table one entry per cycle through a single compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_scan #(
  parameter int TASK_COUNT = rts_pkg::TASK_COUNT_DEF,
  localparam int IW        = $clog2(TASK_COUNT),
  localparam int PW        = $clog2(TASK_COUNT + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [IW-1:0]               start_addr,
  input  wire logic [rts_pkg::VAL_W-1:0]   now,
  input  wire rts_pkg::policy_t            policy,
  input  wire logic                        take,
  output logic                             rd_en,
  output logic [IW-1:0]                    rd_addr,
  input  wire rts_pkg::entry_t             rd_entry,
  output rts_pkg::scan_stat_t              stat,
  output logic [PW-1:0]                    pick
);
  import rts_pkg::*;

  scan_state_t       state_r, state_nxt;
  logic [IW-1:0]     addr_r, addr_nxt;
  logic [IW-1:0]     cnt_r, cnt_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [VAL_W-1:0]  now_r;
  policy_t           pol_r;
  logic              best_vld_r, best_vld_nxt;
  logic [IW-1:0]     best_idx_r;
  logic [VAL_W-1:0]  best_key_r;
  logic [VAL_W-1:0]  key;
  logic              hit;
  logic              is_min;
  logic              take_it;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= SC_IDLE;
      cmp_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      best_vld_r <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    cnt_r     <= cnt_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    if (state_r == SC_IDLE && start) begin
      now_r <= now;
      pol_r <= policy;
    end
    if (take_it) begin
      best_idx_r <= cmp_idx_r;
      best_key_r <= key;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    cnt_nxt     = cnt_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    rd_en       = 1'b0;
    case (state_r)
      SC_IDLE: begin
        if (start) begin
          addr_nxt  = start_addr;
          cnt_nxt   = '0;
          state_nxt = SC_SCAN;
        end
      end
      SC_SCAN: begin
        rd_en       = 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = addr_r;
        addr_nxt    = (addr_r == IW'(TASK_COUNT - 1)) ? '0 : addr_r + 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == IW'(TASK_COUNT - 1)) begin
          state_nxt = SC_DRAIN;
        end
      end
      SC_DRAIN: begin
        state_nxt = SC_HOLD;
      end
      SC_HOLD: begin
        if (take) begin
          state_nxt = SC_IDLE;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  // Shared compare unit: one entry per cycle, compared in the cycle after its read.
  // Entries arrive in search order, so a strict compare keeps the lower id.
  always_comb begin
    key     = (pol_r == POL_EDF) ? rd_entry.deadline : rd_entry.period;
    is_min  = (pol_r == POL_RM) || (pol_r == POL_EDF);
    hit     = cmp_vld_r && (rd_entry.release_time <= now_r) && (rd_entry.work != '0);
    take_it = hit && (!best_vld_r || (is_min && (key < best_key_r)));
    if (state_r == SC_IDLE && start) begin
      best_vld_nxt = 1'b0;
    end else if (take_it) begin
      best_vld_nxt = 1'b1;
    end else begin
      best_vld_nxt = best_vld_r;
    end
  end

  assign rd_addr   = addr_r;
  assign stat.busy = (state_r != SC_IDLE);
  assign stat.done = (state_r == SC_HOLD);
  assign pick      = best_vld_r ? PW'(best_idx_r) : PW'(TASK_COUNT);

endmodule

`default_nettype wire

// ----- hdl/ready_task_selector.sv -----
// ----------------------------------------------------------------------------
// Ready task selector
// Task table with a policy-driven pick of one ready task per schedule command.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries commands. A write command loads period, deadline, release
//   time and remaining work into entry task_id (ids at or above TASK_COUNT are
//   dropped) and gives no result. A schedule command carries now and gives one
//   transaction on out_ch: the chosen task id, or TASK_COUNT with idle set
//   when no entry has release time at or before now and nonzero work.
//   cfg_ch writes the policy register (rate monotonic, earliest deadline,
//   lowest id, round robin) and is always ready; write it only while idle.
// Timing:
//   A write lands in the table as it is accepted. A schedule command sweeps
//   the table once through one compare unit, one entry per cycle from a
//   single memory read port; the sequencer then waits to hand the pick to the
//   result register, and in_ch is ready again as the pick moves in.
// Reset:
//   All entries read as empty, the policy is rate monotonic, and the round
//   robin memory of the previous pick is zero.
// Stall:
//   A finished pick waits in the sequencer while the output register is full and
//   out_ch is not ready; in_ch stays not ready until the output register takes it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ready_task_selector #(
  parameter int TASK_COUNT = rts_pkg::TASK_COUNT_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rts_in_if.sink    in_ch,
  rts_out_if.source out_ch,
  rts_cfg_if.sink   cfg_ch
);
  import rts_pkg::*;

  localparam int IW = $clog2(TASK_COUNT);
  localparam int PW = $clog2(TASK_COUNT + 1);

  policy_t         policy_r;
  logic [PW-1:0]   last_pick_r;
  logic            out_vld_r;
  logic [PW-1:0]   out_pick_r;

  logic            in_acc;
  logic            is_sched;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  entry_t          wr_entry;
  logic            start;
  logic [PW:0]     rr_sum;
  logic [PW:0]     rr_wrap;
  logic [IW-1:0]   start_addr;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  entry_t          rd_entry;
  scan_stat_t      stat;
  logic [PW-1:0]   pick;
  logic            res_take;

  // The sequencer is the only thing that holds the input back.
  assign in_ch.ready = !stat.busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_sched    = (cmd_t'(in_ch.cmd) == CMD_SCHED);
  assign start       = in_acc && is_sched;

  assign wr_en = in_acc && !is_sched && (32'(in_ch.task_id) < 32'(TASK_COUNT));
  assign wr_addr               = IW'(in_ch.task_id);
  assign wr_entry.period       = in_ch.period;
  assign wr_entry.deadline     = in_ch.deadline;
  assign wr_entry.release_time = in_ch.release_time;
  assign wr_entry.work         = in_ch.remaining_work;

  // Round robin starts one past the previous pick. That pick is at most
  // TASK_COUNT, so a single subtract brings the sum back into range.
  always_comb begin
    rr_sum  = {1'b0, last_pick_r} + 1'b1;
    rr_wrap = (rr_sum >= (PW + 1)'(TASK_COUNT)) ? rr_sum - (PW + 1)'(TASK_COUNT) : rr_sum;
    start_addr = (policy_r == POL_RR) ? IW'(rr_wrap) : '0;
  end

  rts_table #(
    .TASK_COUNT (TASK_COUNT)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  rts_scan #(
    .TASK_COUNT (TASK_COUNT)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_addr (start_addr),
    .now        (in_ch.now),
    .policy     (policy_r),
    .take       (res_take),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_entry   (rd_entry),
    .stat       (stat),
    .pick       (pick)
  );

  // The pick moves into the output register once that register is free.
  assign res_take = stat.done && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_RM;
      last_pick_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        policy_r <= policy_t'(cfg_ch.policy);
      end
      if (res_take) begin
        last_pick_r <= pick;
        out_vld_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_pick_r <= pick;
    end
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.chosen_task = CHOSEN_W'(out_pick_r);
  assign out_ch.idle        = (out_pick_r == PW'(TASK_COUNT));

  `ASSERT_IMPL(a_ready_not_busy, in_ch.ready, !stat.busy)
  `ASSERT_NEXT(a_sched_starts_scan, start, stat.busy)
  `ASSERT_NEXT(a_take_fills_output, res_take, out_vld_r && !stat.busy)
  `ASSERT_ALWAYS(a_last_pick_range, last_pick_r <= PW'(TASK_COUNT))

endmodule

`default_nettype wire

// ----- dv/ready_task_selector_tb.sv -----
// ----------------------------------------------------------------------------
// Ready task selector testbench
// Drives write and schedule commands into the task selector under every
// policy, predicts each pick from a local copy of the task table, and checks
// every result transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ready_task_selector_tb;
  import rts_pkg::*;

  localparam int TASKS      = TASK_COUNT_DEF;
  // This settle time covers any command still in flight once the queues are empty.
  localparam int SETTLE     = 2 * (TASKS + 3);
  localparam int CYCLE_CAP  = 400000;
  localparam int PRINT_CAP  = 40;

  // One command as it travels on the input channel.
  typedef struct {
    cmd_t             cmd;
    logic [ID_W-1:0]  task_id;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] deadline;
    logic [VAL_W-1:0] release_time;
    logic [VAL_W-1:0] remaining_work;
    logic [VAL_W-1:0] now;
  } sched_req_t;

  // One pick as it leaves on the result channel.
  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen;
    logic                idle;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n;

  rts_in_if  in_if ();
  rts_out_if out_if ();
  rts_cfg_if cfg_if ();

  ready_task_selector u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared bookkeeping between the stimulus, the driver and the monitor.
  // --------------------------------------------------------------------------
  sched_req_t pending_reqs[$];
  pick_t      expected_picks[$];
  int         queued_count   = 0;
  int         accepted_count = 0;
  int         error_count    = 0;
  int         cycle_count    = 0;
  logic       in_fire        = 1'b0;

  // Predicted copy of the task table, the policy register and the round
  // robin memory. The tables start empty, exactly as after reset.
  logic [VAL_W-1:0] period_tab  [TASKS] = '{default: '0};
  logic [VAL_W-1:0] deadline_tab[TASKS] = '{default: '0};
  logic [VAL_W-1:0] release_tab [TASKS] = '{default: '0};
  logic [VAL_W-1:0] work_tab    [TASKS] = '{default: '0};
  policy_t          policy_reg          = POL_RM;
  int               last_pick           = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  // --------------------------------------------------------------------------
  // Predictor.
  // --------------------------------------------------------------------------
  function automatic bit task_is_ready(input int k, input logic [VAL_W-1:0] now);
    return (release_tab[k] <= now) && (work_tab[k] != '0);
  endfunction

  // Picks one ready entry under the current policy. The answer is TASKS
  // when nothing is ready. Strict less-than comparisons in an upward scan
  // leave ties with the lowest id.
  function automatic int select_ready_task(input logic [VAL_W-1:0] now);
    int best;
    int start;
    int k;
    best = TASKS;
    case (policy_reg)
      POL_RM: begin
        for (k = 0; k < TASKS; k++) begin
          if (task_is_ready(k, now) && (best == TASKS || period_tab[k] < period_tab[best])) begin
            best = k;
          end
        end
      end
      POL_EDF: begin
        for (k = 0; k < TASKS; k++) begin
          if (task_is_ready(k, now) &&
              (best == TASKS || deadline_tab[k] < deadline_tab[best])) begin
            best = k;
          end
        end
      end
      POL_FIFO: begin
        for (k = TASKS - 1; k >= 0; k--) begin
          if (task_is_ready(k, now)) begin
            best = k;
          end
        end
      end
      default: begin
        // Round robin resumes one past the previous answer, and that answer
        // may be TASKS itself after a schedule that found nothing ready.
        start = (last_pick + 1) % TASKS;
        for (int i = 0; i < TASKS; i++) begin
          k = (start + i) % TASKS;
          if (best == TASKS && task_is_ready(k, now)) begin
            best = k;
          end
        end
      end
    endcase
    return best;
  endfunction

  // Applies one accepted command to the predicted state. A write only
  // updates the table; a schedule queues the pick that must come out.
  task automatic apply_command(input sched_req_t req);
    int    pick;
    pick_t res;
    if (req.cmd == CMD_WRITE) begin
      if (int'(req.task_id) < TASKS) begin
        period_tab[req.task_id]   = req.period;
        deadline_tab[req.task_id] = req.deadline;
        release_tab[req.task_id]  = req.release_time;
        work_tab[req.task_id]     = req.remaining_work;
      end
    end else begin
      pick       = select_ready_task(req.now);
      last_pick  = pick;
      res.chosen = CHOSEN_W'(pick);
      res.idle   = (pick == TASKS);
      expected_picks.push_back(res);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. Accepted commands feed
  // the predictor, accepted results are checked against the oldest pick.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sched_req_t req;
    pick_t      want;
    in_fire <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        policy_reg = policy_t'(cfg_if.policy);
      end
      if (in_if.valid && in_if.ready) begin
        req.cmd            = cmd_t'(in_if.cmd);
        req.task_id        = in_if.task_id;
        req.period         = in_if.period;
        req.deadline       = in_if.deadline;
        req.release_time   = in_if.release_time;
        req.remaining_work = in_if.remaining_work;
        req.now            = in_if.now;
        apply_command(req);
        accepted_count <= accepted_count + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_picks.size() == 0) begin
          report_mismatch($sformatf("result chosen_task=%0d idle=%0b with no pick pending",
                                    out_if.chosen_task, out_if.idle));
        end else begin
          want = expected_picks.pop_front();
          if (out_if.chosen_task !== want.chosen) begin
            report_mismatch($sformatf("chosen_task=%0d, predicted %0d",
                                      out_if.chosen_task, want.chosen));
          end
          if (out_if.idle !== want.idle) begin
            report_mismatch($sformatf("idle=%0b, predicted %0b", out_if.idle, want.idle));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command driver. It sends in bursts of random length separated by random
  // gaps; a gap of zero gives stretches of back-to-back commands. A command
  // is held until the monitor has seen it accepted.
  // --------------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left   = 0;
  sched_req_t drive_req;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        drive_req = pending_reqs.pop_front();
        in_if.cmd            <= drive_req.cmd;
        in_if.task_id        <= drive_req.task_id;
        in_if.period         <= drive_req.period;
        in_if.deadline       <= drive_req.deadline;
        in_if.release_time   <= drive_req.release_time;
        in_if.remaining_work <= drive_req.remaining_work;
        in_if.now            <= drive_req.now;
        in_if.valid          <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. It switches between always ready, coin-flip ready and
  // mostly stalled, each mode lasting a random number of cycles.
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        default: out_if.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("ready_task_selector_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_req(input sched_req_t req);
    pending_reqs.push_back(req);
    queued_count++;
  endtask

  // A write carries a random now, which the block must ignore.
  task automatic push_write(input int id, input int per, input int dl, input int rel,
                            input int work);
    sched_req_t req;
    req.cmd            = CMD_WRITE;
    req.task_id        = ID_W'(id);
    req.period         = VAL_W'(per);
    req.deadline       = VAL_W'(dl);
    req.release_time   = VAL_W'(rel);
    req.remaining_work = VAL_W'(work);
    req.now            = VAL_W'($urandom);
    push_req(req);
  endtask

  // A schedule carries random entry fields, which the block must ignore.
  task automatic push_sched(input int now);
    sched_req_t req;
    req.cmd            = CMD_SCHED;
    req.task_id        = ID_W'($urandom);
    req.period         = VAL_W'($urandom);
    req.deadline       = VAL_W'($urandom);
    req.release_time   = VAL_W'($urandom);
    req.remaining_work = VAL_W'($urandom);
    req.now            = VAL_W'(now);
    push_req(req);
  endtask

  // Sorting keys are mostly small so that ties between entries are common.
  function automatic logic [VAL_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0, 1:    return VAL_W'($urandom_range(1, 6));
      2:       return VAL_W'($urandom);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // Random traffic around a moving time base: entries are released close to
  // the times that the schedule commands ask about, some with no work left.
  // A small share is fully random noise over every field.
  task automatic push_random(input int n);
    sched_req_t req;
    int         base;
    int         kind;
    base = $urandom_range(0, 65535);
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        req.cmd            = cmd_t'($urandom_range(0, 1));
        req.task_id        = ID_W'($urandom);
        req.period         = VAL_W'($urandom);
        req.deadline       = VAL_W'($urandom);
        req.release_time   = VAL_W'($urandom);
        req.remaining_work = VAL_W'($urandom);
        req.now            = VAL_W'($urandom);
        push_req(req);
      end else if (kind < 55) begin
        push_write($urandom_range(0, TASKS - 1), rand_key(), rand_key(),
                   ($urandom_range(0, 7) == 0) ? $urandom : base + $urandom_range(0, 64),
                   ($urandom_range(0, 4) == 0) ? 0 :
                   ($urandom_range(0, 8) == 0) ? 16'hFFFF : $urandom_range(1, 300));
      end else begin
        base += $urandom_range(0, 6);
        case ($urandom_range(0, 9))
          0:       push_sched($urandom);
          1:       push_sched(0);
          2:       push_sched(16'hFFFF);
          default: push_sched(base + $urandom_range(0, 96));
        endcase
      end
    end
  endtask

  // Waits until every queued command has been accepted and every predicted
  // pick has arrived, then lets a trailing write finish in the block.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (accepted_count != queued_count || expected_picks.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_policy(input policy_t pol);
    @(negedge clk);
    cfg_if.policy <= pol;
    cfg_if.valid  <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  policy_t random_plan[8] = '{POL_RR, POL_RM, POL_EDF, POL_FIFO,
                              POL_RR, POL_EDF, POL_RM, POL_FIFO};

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.cmd            = CMD_WRITE;
    in_if.task_id        = '0;
    in_if.period         = '0;
    in_if.deadline       = '0;
    in_if.release_time   = '0;
    in_if.remaining_work = '0;
    in_if.now            = '0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.policy        = POL_RM;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Rate monotonic straight out of reset. The first schedule sees an empty
    // table. Entries 3 and 5 share a period, so the lower id must win.
    push_sched(0);
    push_write(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_write(7, 0, 0, 0, 0);
    push_write(3, 5, 9, 100, 1);
    push_write(5, 5, 2, 0, 16'hFFFF);
    push_sched(16'hFFFF);
    push_sched(50);
    push_sched(0);
    wait_idle();

    // Earliest deadline, with a deadline tie between entries 2 and 5.
    set_policy(POL_EDF);
    push_write(2, 1, 2, 0, 1);
    push_sched(16'hFFFF);
    push_sched(0);
    wait_idle();

    // Lowest id first.
    set_policy(POL_FIFO);
    push_sched(16'hFFFF);
    push_sched(99);
    wait_idle();

    // Round robin: a schedule with nothing ready leaves TASKS as the previous
    // pick, so the next search starts at id 1 and skips the ready entry 0.
    // The one after that wraps around back to entry 0.
    set_policy(POL_RR);
    push_write(5, 5, 2, 0, 0);
    push_write(2, 1, 2, 0, 0);
    push_sched(0);
    push_write(0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF);
    push_write(1, 7, 7, 0, 3);
    push_sched(0);
    push_sched(0);
    wait_idle();

    // Random traffic, one policy per phase. Each phase drains completely
    // before the policy register is rewritten.
    foreach (random_plan[i]) begin
      set_policy(random_plan[i]);
      push_random(200);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("ready_task_selector_tb passed");
    end else begin
      $display("ready_task_selector_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
